/* hw/rtl/tsc_pkg.sv */
// ============================================================================
// Thresholded star centroid package
// Shared constants and types for the centroid block.
// ============================================================================
package tsc_pkg;

   localparam int DefMaxHalf  = 31;
   localparam int DefFracBits = 8;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_WIDTH  = 3'd0,
      CSR_HEIGHT = 3'd1,
      CSR_HALF   = 3'd2,
      CSR_KSIG   = 3'd3,
      CSR_STRICT = 3'd4
   } csr_index_type;

   // Request to the shared divider.
   typedef struct packed {
      logic        start;
      logic [63:0] num;
      logic [63:0] den;
   } div_req_type;

   // Status back from the shared divider.
   typedef struct packed {
      logic        done;
      logic [63:0] quot;
      logic [63:0] rem;
   } div_rsp_type;

endpackage

/* hw/rtl/tsc_divider.sv */
// ============================================================================
// Thresholded star centroid divider
// Restoring radix-2 divider, one quotient bit per cycle, 64 bit operands.
// ============================================================================
module tsc_divider
   import tsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [63:0] quot_ff, quot_in;
   logic [64:0] rem_ff, rem_in;
   logic [63:0] den_ff, den_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;

   // One shift and trial subtract per cycle.
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[63:0], quot_ff[63]};
      if (req.start) begin
         quot_in = req.num;
         rem_in  = '0;
         den_in  = req.den;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = trial - {1'b0, den_ff};
            quot_in = {quot_ff[62:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;
   assign rsp.rem  = rem_ff[63:0];

endmodule

/* hw/rtl/tsc_multiplier.sv */
// ============================================================================
// Thresholded star centroid multiplier
// Shift-add multiplier, 64 by 64 bits to 128, one bit per cycle.
// ============================================================================
module tsc_multiplier
   import tsc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  op_a,
   input  logic [63:0]  op_b,
   output logic         done,
   output logic [127:0] product
);

   logic [127:0] acc_ff, acc_in;
   logic [63:0]  b_ff, b_in;
   logic [63:0]  a_ff, a_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [64:0]  upper;

   // Add the multiplicand into the upper half, then shift right.
   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      upper   = {1'b0, acc_ff[127:64]} + (b_ff[0] ? {1'b0, a_ff} : 65'd0);
      if (start) begin
         acc_in  = '0;
         a_in    = op_a;
         b_in    = op_b;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {upper, acc_ff[63:1]};
         b_in   = {1'b0, b_ff[63:1]};
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

/* hw/rtl/thresholded_star_centroid_top.sv */
// ============================================================================
// Thresholded star centroid
// Window capture, k-sigma threshold and weighted centroid sequencer.
// ============================================================================
// Usage: a transaction with req_mode = 0 gives a centre in Q16.8; the block
// rounds it, clips a square window to the image and then takes the window's
// pixels as transactions with req_mode = 1, one per cycle, in raster order.
// An empty image or a degenerate window answers in the cycle after the start.
// After the last pixel the block goes busy and runs a compute pass on the
// shared shift-add multiplier and restoring divider. Three products give
// the variance and threshold. Each stored pixel then takes one memory read
// and one product for the threshold test, plus two more products for the
// position sums when it carries weight. Four divisions give the two
// coordinates; the peak fallback needs one division and a strict failure
// none. The result follows in the next cycle, and the next start is taken
// then.
// Each result shows for one cycle under rsp_valid; the receiver cannot stall.
// Reset clears all control state and loads the register defaults; the
// window memory needs no clearing because only written entries are read.
// ============================================================================
module thresholded_star_centroid_top
   import tsc_pkg::*;
#(
   parameter int MAX_HALF  = DefMaxHalf,
   parameter int FRAC_BITS = DefFracBits
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [23:0] req_center_x,
   input  logic [23:0] req_center_y,
   input  logic [15:0] req_pixel,
   output logic        rsp_valid,
   output logic        rsp_found,
   output logic [23:0] rsp_centroid_x,
   output logic [23:0] rsp_centroid_y,
   output logic        rsp_used_peak,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int Side   = 2 * MAX_HALF + 1;
   localparam int Depth  = Side * Side;
   localparam int AddrW  = $clog2(Depth);
   localparam int CntW   = $clog2(Depth + 1);
   localparam int SideW  = $clog2(Side + 1);
   localparam int HalfW  = $clog2(MAX_HALF + 1);

   typedef enum logic [4:0] {
      ST_IDLE, ST_NQ, ST_SS, ST_VAR, ST_K2, ST_RD, ST_RD2, ST_ND, ST_L2,
      ST_R2, ST_TEST, ST_WX, ST_WXA, ST_WY, ST_WYA, ST_NEXT, ST_DIV,
      ST_FRAC, ST_FDIV, ST_PICK
   } state_type;

   // Configuration registers.
   logic [15:0] width_ff, height_ff;
   logic [4:0]  half_ff;
   logic [11:0] ksig_ff;
   logic        strict_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
         half_ff   <= 5'd8;
         ksig_ff   <= 12'd768;
         strict_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_data;
            CSR_HEIGHT: height_ff <= csr_data;
            CSR_HALF:   half_ff   <= csr_data[4:0];
            CSR_KSIG:   ksig_ff   <= csr_data[11:0];
            CSR_STRICT: strict_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Window memory.
   logic [15:0] mem [Depth];
   logic [15:0] rd_data_ff;
   logic [AddrW-1:0] rd_addr;
   logic        mem_we;
   logic [AddrW-1:0] wr_addr;

   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= req_pixel;
      rd_data_ff <= mem[rd_addr];
   end

   // Shared units.
   logic         mul_start, mul_done;
   logic [63:0]  mul_a, mul_b;
   logic [127:0] mul_p;
   div_req_type  dreq;
   div_rsp_type  drsp;

   tsc_multiplier u_mul (
      .clock(clock), .reset(reset), .start(mul_start),
      .op_a(mul_a), .op_b(mul_b), .done(mul_done), .product(mul_p)
   );

   tsc_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // Sequencer state.
   state_type   state_ff;
   logic        pend_ff;
   logic [15:0] left_ff, top_ff;
   logic [SideW-1:0] cols_ff;
   logic [CntW-1:0]  count_ff, total_ff, idx_ff;
   logic [SideW-1:0] col_ff, row_ff;
   logic [27:0] sum_ff;
   logic [43:0] sq_ff;
   logic [15:0] peak_ff;
   logic [CntW-1:0] peak_off_ff;
   logic [127:0] nq_ff, dvar_ff, k2d_ff, l2_ff;
   logic [63:0]  d_ff;
   logic [63:0]  w0_ff, w1_ff, w2_ff, qx_ff;
   logic         dsel_ff, mstart_ff;
   logic [63:0]  ma_ff, mb_ff;
   logic         dstart_ff;
   logic [63:0]  dnum_ff, dden_ff;
   logic [23:0]  resx_ff;
   logic [AddrW-1:0] raddr_ff;
   logic         rv_ff, rf_ff, rp_ff;
   logic [23:0]  rx_ff, ry_ff;

   assign mul_start = mstart_ff;
   assign mul_a     = ma_ff;
   assign mul_b     = mb_ff;
   assign dreq.start = dstart_ff;
   assign dreq.num   = dnum_ff;
   assign dreq.den   = dden_ff;
   assign rd_addr    = raddr_ff;

   // Start decode: centre rounding and window clipping.
   logic signed [24:0] cxr, cyr, hs;
   logic signed [24:0] x0, y0, x1, y1, wm1, hm1;
   logic [HalfW-1:0]   hclip;

   function automatic logic signed [24:0] round_c(input logic [23:0] c);
      logic signed [24:0] cs;
      logic signed [24:0] mag;
      cs  = {c[23], c};
      mag = cs[24] ? -cs : cs;
      mag = (mag + (25'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      return cs[24] ? -mag : mag;
   endfunction

   always_comb begin
      hclip = (32'(half_ff) > MAX_HALF) ? HalfW'(MAX_HALF) : HalfW'(half_ff);
      hs  = 25'(hclip);
      cxr = round_c(req_center_x);
      cyr = round_c(req_center_y);
      wm1 = 25'(width_ff) - 25'sd1;
      hm1 = 25'(height_ff) - 25'sd1;
      x0  = (cxr - hs < 0) ? 25'sd0 : cxr - hs;
      y0  = (cyr - hs < 0) ? 25'sd0 : cyr - hs;
      x1  = (cxr + hs > wm1) ? wm1 : cxr + hs;
      y1  = (cyr + hs > hm1) ? hm1 : cyr + hs;
   end

   logic        accept, is_last;
   logic [CntW-1:0] cnt_next;
   assign accept   = start && !busy;
   assign cnt_next = count_ff + CntW'(1);
   assign is_last  = (cnt_next == total_ff);
   assign mem_we   = accept && req_mode && pend_ff;
   assign wr_addr  = count_ff[AddrW-1:0];
   assign busy     = (state_ff != ST_IDLE);

   // Threshold sign helpers.
   logic        kneg;
   logic [11:0] kabs;
   assign kneg = ksig_ff[11];
   assign kabs = kneg ? (~ksig_ff + 12'd1) : ksig_ff;

   // Main sequencer.
   always_ff @(posedge clock) begin
      mstart_ff <= 1'b0;
      dstart_ff <= 1'b0;
      rv_ff     <= 1'b0;
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
         count_ff <= '0;
         total_ff <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept && !req_mode) begin
                  pend_ff <= 1'b0;
                  if (width_ff == 16'd0 || height_ff == 16'd0 || x1 <= x0 || y1 <= y0) begin
                     rv_ff <= 1'b1; rf_ff <= 1'b0; rp_ff <= 1'b0;
                     rx_ff <= '0; ry_ff <= '0;
                  end else begin
                     pend_ff  <= 1'b1;
                     left_ff  <= x0[15:0];
                     top_ff   <= y0[15:0];
                     cols_ff  <= SideW'(x1 - x0 + 25'sd1);
                     total_ff <= CntW'((x1 - x0 + 25'sd1) * (y1 - y0 + 25'sd1));
                     count_ff <= '0;
                     sum_ff   <= '0;
                     sq_ff    <= '0;
                     peak_ff  <= '0;
                     peak_off_ff <= '0;
                  end
               end else if (mem_we) begin
                  sum_ff   <= sum_ff + 28'(req_pixel);
                  sq_ff    <= sq_ff + 44'(32'(req_pixel) * 32'(req_pixel));
                  if (req_pixel > peak_ff) begin
                     peak_ff <= req_pixel;
                     peak_off_ff <= count_ff;
                  end
                  count_ff <= cnt_next;
                  if (is_last) begin
                     pend_ff   <= 1'b0;
                     state_ff  <= ST_NQ;
                     ma_ff     <= 64'(cnt_next);
                     mb_ff     <= 64'(sq_ff + 44'(32'(req_pixel) * 32'(req_pixel)));
                     mstart_ff <= 1'b1;
                  end
               end
            end
            ST_NQ: if (mul_done) begin
               nq_ff     <= mul_p;
               ma_ff     <= 64'(sum_ff);
               mb_ff     <= 64'(sum_ff);
               mstart_ff <= 1'b1;
               state_ff  <= ST_SS;
            end
            ST_SS: if (mul_done) begin
               dvar_ff   <= (nq_ff > mul_p) ? nq_ff - mul_p : '0;
               state_ff  <= ST_VAR;
            end
            ST_VAR: begin
               ma_ff     <= 64'(24'(kabs) * 24'(kabs));
               mb_ff     <= dvar_ff[63:0];
               mstart_ff <= 1'b1;
               state_ff  <= ST_K2;
            end
            ST_K2: if (mul_done) begin
               k2d_ff   <= mul_p;
               w0_ff <= '0; w1_ff <= '0; w2_ff <= '0;
               idx_ff   <= '0; col_ff <= '0; row_ff <= '0;
               raddr_ff <= '0;
               state_ff <= ST_RD;
            end
            ST_RD:  state_ff <= ST_RD2;
            ST_RD2: begin
               // Signed excess d = n*v - S, held in 64 bits.
               d_ff     <= 64'(28'(count_ff) * 28'(rd_data_ff)) - 64'(sum_ff);
               state_ff <= ST_ND;
            end
            ST_ND: begin
               ma_ff     <= d_ff[63] ? (~d_ff + 64'd1) << FRAC_BITS : d_ff << FRAC_BITS;
               mb_ff     <= d_ff[63] ? (~d_ff + 64'd1) << FRAC_BITS : d_ff << FRAC_BITS;
               mstart_ff <= 1'b1;
               state_ff  <= ST_L2;
            end
            ST_L2: if (mul_done) begin
               l2_ff    <= mul_p;
               state_ff <= ST_TEST;
            end
            ST_TEST: begin
               // Negative k passes every above-mean pixel; below-mean pixels carry no weight.
               if (!d_ff[63] && d_ff != 64'd0 &&
                   (kneg || l2_ff >= k2d_ff)) begin
                  w0_ff     <= w0_ff + d_ff;
                  ma_ff     <= 64'(left_ff) + 64'(col_ff);
                  mb_ff     <= d_ff;
                  mstart_ff <= 1'b1;
                  state_ff  <= ST_WX;
               end else begin
                  state_ff <= ST_NEXT;
               end
            end
            ST_WX: if (mul_done) begin
               w1_ff    <= w1_ff + mul_p[63:0];
               state_ff <= ST_WXA;
            end
            ST_WXA: begin
               ma_ff     <= 64'(top_ff) + 64'(row_ff);
               mb_ff     <= d_ff;
               mstart_ff <= 1'b1;
               state_ff  <= ST_WY;
            end
            ST_WY: if (mul_done) begin
               w2_ff    <= w2_ff + mul_p[63:0];
               state_ff <= ST_NEXT;
            end
            ST_NEXT: begin
               if (idx_ff + CntW'(1) == count_ff) begin
                  if (w0_ff != 64'd0) begin
                     dnum_ff   <= w1_ff;
                     dden_ff   <= w0_ff;
                     dstart_ff <= 1'b1;
                     dsel_ff   <= 1'b0;
                     state_ff  <= ST_DIV;
                  end else begin
                     state_ff <= ST_PICK;
                  end
               end else begin
                  idx_ff   <= idx_ff + CntW'(1);
                  raddr_ff <= AddrW'(idx_ff + CntW'(1));
                  if (col_ff + SideW'(1) == cols_ff) begin
                     col_ff <= '0;
                     row_ff <= row_ff + SideW'(1);
                  end else begin
                     col_ff <= col_ff + SideW'(1);
                  end
                  state_ff <= ST_RD;
               end
            end
            ST_DIV: if (drsp.done) begin
               qx_ff     <= drsp.quot;
               dnum_ff   <= (drsp.rem << FRAC_BITS) + (w0_ff >> 1);
               dden_ff   <= w0_ff;
               dstart_ff <= 1'b1;
               state_ff  <= ST_FDIV;
            end
            ST_FDIV: if (drsp.done) begin
               if (!dsel_ff) begin
                  resx_ff   <= 24'((qx_ff << FRAC_BITS) + drsp.quot);
                  dsel_ff   <= 1'b1;
                  dnum_ff   <= w2_ff;
                  dden_ff   <= w0_ff;
                  dstart_ff <= 1'b1;
                  state_ff  <= ST_DIV;
               end else begin
                  rv_ff <= 1'b1; rf_ff <= 1'b1; rp_ff <= 1'b0;
                  rx_ff <= resx_ff;
                  ry_ff <= 24'((qx_ff << FRAC_BITS) + drsp.quot);
                  state_ff <= ST_IDLE;
               end
            end
            ST_PICK: begin
               // Peak fallback: offset split into column and row serially.
               if (strict_ff) begin
                  rv_ff <= 1'b1; rf_ff <= 1'b0; rp_ff <= 1'b0;
                  rx_ff <= '0; ry_ff <= '0;
                  state_ff <= ST_IDLE;
               end else begin
                  dnum_ff   <= 64'(peak_off_ff);
                  dden_ff   <= 64'(cols_ff);
                  dstart_ff <= 1'b1;
                  state_ff  <= ST_FRAC;
               end
            end
            ST_FRAC: if (drsp.done) begin
               rv_ff <= 1'b1; rf_ff <= 1'b1; rp_ff <= 1'b1;
               rx_ff <= 24'((64'(left_ff) + drsp.rem) << FRAC_BITS);
               ry_ff <= 24'((64'(top_ff) + drsp.quot) << FRAC_BITS);
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rv_ff;
   assign rsp_found      = rf_ff;
   assign rsp_centroid_x = rx_ff;
   assign rsp_centroid_y = ry_ff;
   assign rsp_used_peak  = rp_ff;

   // A failure carries a zero x position and no peak flag.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_centroid_x == 24'd0 && !rsp_used_peak)
      else $error("failure result carries data");

   // No transaction is taken while the compute pass runs.
   a_busy_hold: assert property (@(posedge clock) disable iff (reset)
      busy && state_ff != ST_IDLE |=> !mem_we || state_ff == ST_IDLE)
      else $error("pixel written during compute");

   // A result always returns the sequencer to idle.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ST_IDLE)
      else $error("result outside idle");

endmodule
